>>> rtl/core/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; used by every module in rtl/core.
package ps2mpt_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned POS_OUT_W     = 16;
  localparam int unsigned DELTA_W       = 9;
  localparam int unsigned BTN_W         = 3;

  localparam int unsigned HEAD_SYNC_BIT  = 3;
  localparam int unsigned HEAD_XSIGN_BIT = 4;
  localparam int unsigned HEAD_YSIGN_BIT = 5;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] move_x;
    logic [7:0] move_y;
  } packet_t;

endpackage

>>> rtl/core/ps2mpt_framer.sv
// Byte slot tracker: syncs on the head byte and frames 3-byte packets.
// Depends on ps2mpt_pkg.
module ps2mpt_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic                advance_i,
  input  logic [7:0]          rx_byte_i,
  output logic                pkt_valid_o,
  output ps2mpt_pkg::packet_t pkt_o
);
  import ps2mpt_pkg::*;

  typedef enum logic [1:0] {
    SLOT_HEAD = 2'd0,
    SLOT_X    = 2'd1,
    SLOT_Y    = 2'd2
  } slot_e;

  slot_e      slot_q, slot_d;
  logic [7:0] head_q, head_d;
  logic [7:0] move_x_q, move_x_d;

  always_comb begin
    slot_d   = slot_q;
    head_d   = head_q;
    move_x_d = move_x_q;
    unique case (slot_q)
      SLOT_HEAD: begin
        if (rx_byte_i[HEAD_SYNC_BIT]) begin
          head_d = rx_byte_i;
          slot_d = SLOT_X;
        end
      end
      SLOT_X: begin
        move_x_d = rx_byte_i;
        slot_d   = SLOT_Y;
      end
      SLOT_Y: slot_d = SLOT_HEAD;
      default: slot_d = SLOT_HEAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= SLOT_HEAD;
      head_q   <= '0;
      move_x_q <= '0;
    end else if (advance_i) begin
      slot_q   <= slot_d;
      head_q   <= head_d;
      move_x_q <= move_x_d;
    end
  end

  assign pkt_valid_o     = byte_valid_i && (slot_q == SLOT_Y);
  assign pkt_o.head_byte = head_q;
  assign pkt_o.move_x    = move_x_q;
  assign pkt_o.move_y    = rx_byte_i;

endmodule

>>> rtl/core/ps2mpt_tracker.sv
// Position and button accumulator with the result register.
// Depends on ps2mpt_pkg.
module ps2mpt_tracker #(
  parameter int unsigned POS_WIDTH = ps2mpt_pkg::POS_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pkt_fire_i,
  input  ps2mpt_pkg::packet_t                  pkt_i,
  output logic                                 out_busy_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ps2mpt_pkg::POS_OUT_W-1:0] pos_x_o,
  output logic signed [ps2mpt_pkg::POS_OUT_W-1:0] pos_y_o,
  output logic signed [ps2mpt_pkg::DELTA_W-1:0]   delta_x_o,
  output logic signed [ps2mpt_pkg::DELTA_W-1:0]   delta_y_o,
  output logic [ps2mpt_pkg::BTN_W-1:0]            buttons_down_o,
  output logic [ps2mpt_pkg::BTN_W-1:0]            buttons_released_o
);
  import ps2mpt_pkg::*;

  logic                 out_valid_q;
  logic [POS_WIDTH-1:0] pos_x_q, pos_x_d;
  logic [POS_WIDTH-1:0] pos_y_q, pos_y_d;
  logic [DELTA_W-1:0]   dx_q, dx_d;
  logic [DELTA_W-1:0]   dy_q, dy_d;
  logic [BTN_W-1:0]     held_q, held_d;
  logic [BTN_W-1:0]     rel_q, rel_d;

  always_comb begin
    dx_d    = {pkt_i.head_byte[HEAD_XSIGN_BIT], pkt_i.move_x};
    dy_d    = {pkt_i.head_byte[HEAD_YSIGN_BIT], pkt_i.move_y};
    pos_x_d = pos_x_q + {{(POS_WIDTH-DELTA_W){dx_d[DELTA_W-1]}}, dx_d};
    pos_y_d = pos_y_q - {{(POS_WIDTH-DELTA_W){dy_d[DELTA_W-1]}}, dy_d};
    held_d  = pkt_i.head_byte[BTN_W-1:0];
    rel_d   = held_q & ~held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      held_q      <= '0;
      rel_q       <= '0;
    end else begin
      if (pkt_fire_i) begin
        out_valid_q <= 1'b1;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        held_q      <= held_d;
        rel_q       <= rel_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_fire_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign out_busy_o         = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign pos_x_o            = POS_OUT_W'(pos_x_q);
  assign pos_y_o            = POS_OUT_W'(pos_y_q);
  assign delta_x_o          = dx_q;
  assign delta_y_o          = dy_q;
  assign buttons_down_o     = held_q;
  assign buttons_released_o = rel_q;

endmodule

>>> rtl/core/ps2mpt_tracker_core.sv
// Top level of the PS/2 mouse packet tracker: input register, framer, tracker.
// Depends on ps2mpt_pkg, ps2mpt_framer and ps2mpt_tracker.
//
// One received PS/2 mouse byte is taken per item, one item per clock cycle
// while in_stall_o is low. Bytes pass through an input register, and each
// complete 3-byte packet (head byte with bit 3 set, X byte, Y byte) leaves
// as one result, registered in the output register once its last byte has
// passed the input register; bytes in the head slot without bit 3 are
// dropped. Results sit in a single output register; while it holds an
// untaken result, head and X bytes are still accepted and only a Y byte
// waits. Positions wrap at POS_WIDTH bits and the outputs carry their low 16 bits.
module ps2_mouse_packet_tracker_core #(
  parameter int unsigned POS_WIDTH = ps2mpt_pkg::POS_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [7:0]                              rx_byte_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [ps2mpt_pkg::POS_OUT_W-1:0] pos_x_o,
  output logic signed [ps2mpt_pkg::POS_OUT_W-1:0] pos_y_o,
  output logic signed [ps2mpt_pkg::DELTA_W-1:0]   delta_x_o,
  output logic signed [ps2mpt_pkg::DELTA_W-1:0]   delta_y_o,
  output logic [ps2mpt_pkg::BTN_W-1:0]            buttons_down_o,
  output logic [ps2mpt_pkg::BTN_W-1:0]            buttons_released_o
);
  import ps2mpt_pkg::*;

  logic       in_valid_q;
  logic [7:0] rx_q;
  logic       pkt_valid;
  logic       pkt_fire;
  logic       out_busy;
  logic       blocked;
  logic       advance;
  packet_t    pkt;

  assign blocked    = pkt_valid && out_busy;
  assign in_stall_o = in_valid_q && blocked;
  assign advance    = in_valid_q && !blocked;
  assign pkt_fire   = pkt_valid && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      rx_q <= rx_byte_i;
    end
  end

  ps2mpt_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_q),
    .advance_i    (advance),
    .rx_byte_i    (rx_q),
    .pkt_valid_o  (pkt_valid),
    .pkt_o        (pkt)
  );

  ps2mpt_tracker #(
    .POS_WIDTH (POS_WIDTH)
  ) u_tracker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pkt_fire_i         (pkt_fire),
    .pkt_i              (pkt),
    .out_busy_o         (out_busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pos_x_o            (pos_x_o),
    .pos_y_o            (pos_y_o),
    .delta_x_o          (delta_x_o),
    .delta_y_o          (delta_y_o),
    .buttons_down_o     (buttons_down_o),
    .buttons_released_o (buttons_released_o)
  );

  a_stall_only_when_out_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register is free");

  a_fire_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pkt_fire |=> out_valid_o)
    else $error("completed packet produced no result");

  a_release_excludes_down: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((buttons_released_o & buttons_down_o) == '0))
    else $error("button reported both down and released");

  a_fire_only_on_free_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pkt_fire |-> !(out_valid_o && out_stall_i))
    else $error("packet overwrote a stalled result");

endmodule
